### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check with a generic message.
`define WGM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check with a caller-supplied message.
`define WGM_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

### rtl/wgm_pkg.sv
// ----------------------------------------------------------------------------
// Glob matcher package
// Shared constants, register indexes, cell control and byte helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

  localparam int PatternChars = 32;
  localparam int PosCount     = PatternChars + 1;
  localparam int LenW         = 6;
  localparam int CfgDataW     = 64;
  localparam int CfgIdxW      = 3;
  localparam int ByteW        = 8;

  localparam logic [ByteW-1:0] CharStar     = 8'h2A;
  localparam logic [ByteW-1:0] CharQuestion = 8'h3F;
  localparam logic [ByteW-1:0] CharUpperA   = 8'h41;
  localparam logic [ByteW-1:0] CharUpperZ   = 8'h5A;
  localparam logic [ByteW-1:0] CaseOffset   = 8'h20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatWord0 = 3'd0,
    CfgPatWord1 = 3'd1,
    CfgPatWord2 = 3'd2,
    CfgPatWord3 = 3'd3,
    CfgPatLen   = 3'd4,
    CfgFoldCase = 3'd5
  } cfg_index_e;

  // Per-item control broadcast to every cell.
  typedef struct packed {
    logic step;     // a subject byte transfer
    logic restart;  // a terminator transfer
  } wgm_ctrl_t;

  function automatic logic [ByteW-1:0] fold_byte(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c >= CharUpperA && c <= CharUpperZ) r = c + CaseOffset;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/wgm_cell.sv
// ----------------------------------------------------------------------------
// Glob matcher position cell
// Holds one active-position bit and compares its pattern byte to the subject.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wgm_pkg::wgm_ctrl_t        ctrl_i,
  input  logic                      en_i,
  input  logic                      seed_i,
  input  logic [wgm_pkg::ByteW-1:0] pat_byte_i,
  input  logic [wgm_pkg::ByteW-1:0] text_byte_i,
  input  logic                      fold_i,
  input  logic                      closed_i,
  input  logic                      adv_i,
  output logic                      active_o,
  output logic                      link_o,
  output logic                      adv_o
);
  import wgm_pkg::*;

  logic active_q, active_d;
  logic is_star, is_hit;

  assign is_star = (pat_byte_i == CharStar);
  assign is_hit  = (pat_byte_i == CharQuestion) || (pat_byte_i == text_byte_i) ||
                   (fold_i && (fold_byte(pat_byte_i) == fold_byte(text_byte_i)));

  assign active_o = active_q | seed_i;
  assign link_o   = en_i & is_star;
  // A star keeps its own position; a matching byte moves on to the neighbor.
  assign adv_o    = en_i & closed_i & ~is_star & is_hit;

  always_comb begin
    active_d = active_q;
    if (ctrl_i.restart) begin
      active_d = 1'b0;
    end else if (ctrl_i.step) begin
      active_d = (en_i & closed_i & is_star) | adv_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

### rtl/wgm_closure.sv
// ----------------------------------------------------------------------------
// Glob matcher star closure
// Parallel-prefix spread of active bits across star positions.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_closure (
  input  logic [wgm_pkg::PosCount-1:0]     active_i,
  input  logic [wgm_pkg::PatternChars-1:0] link_i,
  input  logic [wgm_pkg::LenW-1:0]         len_i,
  output logic [wgm_pkg::PosCount-1:0]     closed_o
);
  import wgm_pkg::*;

  localparam int Levels = $clog2(PosCount);

  logic [PosCount-1:0] g_lvl [Levels+1];
  logic [PosCount-1:0] p_lvl [Levels+1];

  // Bit j propagates from j-1 when position j-1 is an in-range star.
  always_comb begin
    for (int j = 0; j < PosCount; j++) begin
      g_lvl[0][j] = active_i[j] & (LenW'(j) <= len_i);
      p_lvl[0][j] = (j == 0) ? 1'b0 : link_i[(j == 0) ? 0 : j - 1];
    end
    for (int l = 0; l < Levels; l++) begin
      for (int j = 0; j < PosCount; j++) begin
        if (j >= (1 << l)) begin
          g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j - (1 << l)]);
          p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j - (1 << l)];
        end else begin
          g_lvl[l+1][j] = g_lvl[l][j];
          p_lvl[l+1][j] = 1'b0;
        end
      end
    end
  end

  assign closed_o = g_lvl[Levels];

endmodule

`default_nettype wire

### rtl/wildcard_glob_matcher.sv
// A terminator transfer's result is registered and shows on the output in the next cycle.
// Throughput: one subject byte or terminator per cycle, set by the combinational
// star closure prefix network and the per-position cell update.
// The input stalls only while a result waits and the output is not ready.
// Reset: asynchronous, active low; clears the registers but start_q, which it sets,
// making position zero the only active position.
`default_nettype none
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// Wildcard glob matcher
// Streams subject bytes through a row of position cells and reports the match.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wgm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wgm_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wgm_pkg::ByteW-1:0]    text_byte_i,
  input  logic                         end_of_string_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         matched_o
);
  import wgm_pkg::*;

  logic [PatternChars*ByteW-1:0] pat_q;
  logic [LenW-1:0]               len_q;
  logic                          fold_q;
  logic                          start_q;
  logic                          term_q, term_d;
  logic                          out_valid_q;
  logic                          matched_q;

  logic [LenW-1:0]         len_use;
  logic [PatternChars-1:0] en;
  logic [PatternChars-1:0] link;
  logic [PosCount-1:0]     active;
  logic [PosCount-1:0]     closed;
  logic [PatternChars:0]   adv;
  logic                    in_fire;
  wgm_ctrl_t               ctrl;

  assign len_use = (len_q > LenW'(PatternChars)) ? LenW'(PatternChars) : len_q;

  always_comb begin
    for (int i = 0; i < PatternChars; i++) begin
      en[i] = (LenW'(i) < len_use);
    end
  end

  assign in_ready_o   = ~out_valid_q | out_ready_i;
  assign in_fire      = in_valid_i & in_ready_o;
  assign ctrl.step    = in_fire & ~end_of_string_i;
  assign ctrl.restart = in_fire & end_of_string_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      len_q  <= '0;
      fold_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgPatWord0: pat_q[0*CfgDataW +: CfgDataW] <= cfg_wdata_i;
        CfgPatWord1: pat_q[1*CfgDataW +: CfgDataW] <= cfg_wdata_i;
        CfgPatWord2: pat_q[2*CfgDataW +: CfgDataW] <= cfg_wdata_i;
        CfgPatWord3: pat_q[3*CfgDataW +: CfgDataW] <= cfg_wdata_i;
        CfgPatLen:   len_q  <= cfg_wdata_i[LenW-1:0];
        CfgFoldCase: fold_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign adv[0] = 1'b0;

  for (genvar i = 0; i < PatternChars; i++) begin : g_cell
    wgm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .en_i        (en[i]),
      .seed_i      ((i == 0) ? start_q : 1'b0),
      .pat_byte_i  (pat_q[i*ByteW +: ByteW]),
      .text_byte_i (text_byte_i),
      .fold_i      (fold_q),
      .closed_i    (closed[i]),
      .adv_i       (adv[i]),
      .active_o    (active[i]),
      .link_o      (link[i]),
      .adv_o       (adv[i+1])
    );
  end

  // The last position past the pattern end has no compare of its own.
  assign active[PatternChars] = term_q;

  wgm_closure u_closure (
    .active_i (active),
    .link_i   (link),
    .len_i    (len_use),
    .closed_o (closed)
  );

  always_comb begin
    term_d = term_q;
    if (ctrl.restart) begin
      term_d = 1'b0;
    end else if (ctrl.step) begin
      term_d = adv[PatternChars];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 1'b1;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      term_q <= term_d;
      if (ctrl.restart) begin
        start_q <= 1'b1;
      end else if (ctrl.step) begin
        start_q <= 1'b0;
      end
      if (ctrl.restart) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q <= 1'b0;
    end else if (ctrl.restart) begin
      matched_q <= closed[len_use];
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  `WGM_ASSERT_MSG(a_term_gives_result, ctrl.restart |=> out_valid_o,
                  "terminator transfer produced no result")
  `WGM_ASSERT_MSG(a_start_state_clean,
                  start_q |-> (active == {{PatternChars{1'b0}}, 1'b1}),
                  "start state holds stale active positions")
  `WGM_ASSERT(a_stall_only_on_result, (in_valid_i && !in_ready_o) |-> out_valid_o)

endmodule

`default_nettype wire
